FILE: hdl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/qlss_pkg.sv
// Shared codes, command/status types and grid helper for the launch slot scheduler.
package qlss_pkg;

   // request codes
   localparam logic [2:0] REQ_PRESS   = 3'd0;
   localparam logic [2:0] REQ_RELEASE = 3'd1;
   localparam logic [2:0] REQ_STOP    = 3'd2;
   localparam logic [2:0] REQ_ADVANCE = 3'd3;
   localparam logic [2:0] REQ_CLEAR   = 3'd4;

   // result kinds
   localparam logic [2:0] KIND_APPLIED   = 3'd0;
   localparam logic [2:0] KIND_IGNORED   = 3'd1;
   localparam logic [2:0] KIND_DROPPED   = 3'd2;
   localparam logic [2:0] KIND_STARTED   = 3'd3;
   localparam logic [2:0] KIND_RETRIG    = 3'd4;
   localparam logic [2:0] KIND_STOPPED   = 3'd5;
   localparam logic [2:0] KIND_TICK_DONE = 3'd6;
   localparam logic [2:0] KIND_CLEARED   = 3'd7;

   // slot phases
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_LAUNCH = 2'd1;
   localparam logic [1:0] PH_PLAY   = 2'd2;
   localparam logic [1:0] PH_STOP   = 2'd3;

   // launch modes
   localparam logic [1:0] MODE_TRIGGER = 2'd0;
   localparam logic [1:0] MODE_GATE    = 2'd1;
   localparam logic [1:0] MODE_TOGGLE  = 2'd2;
   localparam logic [1:0] MODE_REPEAT  = 2'd3;

   // quantisation codes with their own grid; every other code is one bar
   localparam logic [2:0] QUANT_NONE = 3'd0;
   localparam logic [2:0] QUANT_TWO  = 3'd2;
   localparam logic [2:0] QUANT_FOUR = 3'd3;

   localparam int TPB_W  = 16;
   localparam int GRID_W = 18;
   localparam logic [TPB_W-1:0] TPB_RESET = 16'd192;

   // source of the fields of an emitted item
   typedef enum logic [2:0] {
      EM_NONE,
      EM_SLOT,
      EM_REQ,
      EM_ZERO,
      EM_EVENT
   } emit_type;

   // controller to datapath
   typedef struct packed {
      logic     load_req;
      logic     ptr_inc;
      logic     ptr_clr;
      logic     scan;
      logic     ptr_sel;
      logic     claim;
      logic     div_start;
      logic     apply;
      logic     adv_eval;
      logic     drop_inc;
      logic     clear_all;
      emit_type emit;
      logic [2:0] emit_kind;
      logic     emit_last;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] req_type;
      logic       ptr_last;
      logic       match_found;
      logic       free_found;
      logic       div_done;
   } dp_stat_type;

   // grid length in ticks for a quantisation code
   function automatic logic [GRID_W-1:0] grid_len(input logic [TPB_W-1:0] tpb,
                                                 input logic [2:0] q);
      logic [GRID_W-1:0] g;
      if (tpb == '0 || q == QUANT_NONE) begin
         g = '0;
      end else if (q == QUANT_FOUR) begin
         g = {tpb, 2'b00};
      end else if (q == QUANT_TWO) begin
         g = {1'b0, tpb, 1'b0};
      end else begin
         g = {2'b00, tpb};
      end
      return g;
   endfunction

endpackage

FILE: hdl/qlss_div.sv
// Bit-serial remainder unit that rounds a position up to the next grid multiple.
`include "assert_macros.svh"
module qlss_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] pos,
   input  logic [qlss_pkg::GRID_W-1:0] grid,
   output logic        done,
   output logic [31:0] t
);
   localparam logic [4:0] LAST_BIT = 5'd30;

   logic        run_ff, fin_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [qlss_pkg::GRID_W-1:0] rem_ff, g_ff, rem_in;
   logic [30:0] sh_ff, pos_ff;
   logic [31:0] t_ff;
   logic [qlss_pkg::GRID_W:0] trial;

   // one restoring step per cycle, MSB first
   always_comb begin
      trial = {rem_ff, sh_ff[30]};
      if (trial >= {1'b0, g_ff}) begin
         rem_in = qlss_pkg::GRID_W'(trial - {1'b0, g_ff});
      end else begin
         rem_in = trial[qlss_pkg::GRID_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            pos_ff <= pos;
            sh_ff  <= pos;
            g_ff   <= grid;
            rem_ff <= '0;
            cnt_ff <= LAST_BIT;
            if (grid == '0) begin
               done_ff <= 1'b1;
               t_ff    <= {1'b0, pos};
            end else begin
               run_ff <= 1'b1;
            end
         end else if (run_ff) begin
            rem_ff <= rem_in;
            sh_ff  <= {sh_ff[29:0], 1'b0};
            if (cnt_ff == '0) begin
               run_ff <= 1'b0;
               fin_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 5'd1;
            end
         end else if (fin_ff) begin
            // exact multiple stays, otherwise step up to the next one
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
            if (rem_ff == '0) begin
               t_ff <= {1'b0, pos_ff};
            end else begin
               t_ff <= {1'b0, pos_ff} + {14'd0, g_ff} - {14'd0, rem_ff};
            end
         end
      end
   end

   assign done = done_ff;
   assign t    = t_ff;

   `ASSERT_ALWAYS(a_no_restart, !(run_ff && start), "divider restarted while running")
endmodule

FILE: hdl/qlss_dp.sv
// Slot table, counters, rounding unit and result register of the scheduler.
`include "assert_macros.svh"
module qlss_dp #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_track,
   input  logic [7:0]  req_scene,
   input  logic [1:0]  req_launch_mode,
   input  logic [2:0]  req_quantisation,
   input  logic [30:0] req_position,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_ticks_per_bar,
   input  qlss_pkg::ctl_cmd_type cmd,
   output qlss_pkg::dp_stat_type stat,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_slot_index,
   output logic [7:0]  rsp_out_track,
   output logic [7:0]  rsp_out_scene,
   output logic [1:0]  rsp_phase,
   output logic [31:0] rsp_scheduled_tick,
   output logic [31:0] rsp_launch_total,
   output logic [31:0] rsp_drop_total,
   output logic [4:0]  rsp_active_slots,
   output logic        rsp_last
);
   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ACTW = $clog2(SLOTS + 1);
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);
   localparam logic [2:0] EV_NONE = 3'd0;

   // configuration and latched request
   logic [15:0] tpb_ff;
   logic [2:0]  rq_type_ff, rq_quant_ff;
   logic [7:0]  rq_track_ff, rq_scene_ff;
   logic [1:0]  rq_mode_ff;
   logic [30:0] rq_pos_ff;

   // walk pointer and search results
   logic [IDXW-1:0] ptr_ff, match_idx_ff, free_idx_ff;
   logic            match_ff, free_ff;

   // slot table
   logic                        used_ff  [SLOTS];
   logic [7:0]                  track_ff [SLOTS];
   logic [7:0]                  scene_ff [SLOTS];
   logic [1:0]                  mode_ff  [SLOTS];
   logic [2:0]                  quant_ff [SLOTS];
   logic [1:0]                  phase_ff [SLOTS];
   logic                        held_ff  [SLOTS];
   logic [31:0]                 pend_ff  [SLOTS];
   logic [31:0]                 start_ff [SLOTS];
   logic [qlss_pkg::GRID_W-1:0] retrig_ff[SLOTS];
   logic [2:0]                  ev_ff    [SLOTS];

   logic [31:0]     launch_ff, drop_ff;
   logic [ACTW-1:0] active_ff;
   logic [qlss_pkg::GRID_W-1:0] grid_ff, grid_sel;

   // result register
   logic        rsp_valid_ff, rsp_last_ff;
   logic [2:0]  rsp_kind_ff;
   logic [3:0]  rsp_idx_ff;
   logic [7:0]  rsp_track_ff, rsp_scene_ff;
   logic [1:0]  rsp_phase_ff;
   logic [31:0] rsp_sched_ff, rsp_launch_ff, rsp_drop_ff;
   logic [4:0]  rsp_active_ff;

   // current slot view
   logic        cur_used, cur_held;
   logic [7:0]  cur_track, cur_scene;
   logic [1:0]  cur_mode, cur_phase;
   logic [2:0]  cur_quant, ev_cur;
   logic [31:0] cur_pend, cur_start;
   logic [qlss_pkg::GRID_W-1:0] cur_retrig;

   logic        div_done;
   logic [31:0] div_t;

   assign cur_used   = used_ff[ptr_ff];
   assign cur_held   = held_ff[ptr_ff];
   assign cur_track  = track_ff[ptr_ff];
   assign cur_scene  = scene_ff[ptr_ff];
   assign cur_mode   = mode_ff[ptr_ff];
   assign cur_phase  = phase_ff[ptr_ff];
   assign cur_quant  = quant_ff[ptr_ff];
   assign cur_pend   = pend_ff[ptr_ff];
   assign cur_start  = start_ff[ptr_ff];
   assign cur_retrig = retrig_ff[ptr_ff];
   assign ev_cur     = ev_ff[ptr_ff];

   // grid of the request (press) or of the stored slot (release, stop)
   assign grid_sel = qlss_pkg::grid_len(tpb_ff,
      (rq_type_ff == qlss_pkg::REQ_PRESS) ? rq_quant_ff : cur_quant);

   qlss_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .pos   (rq_pos_ff),
      .grid  (grid_sel),
      .done  (div_done),
      .t     (div_t)
   );

   // search compare at the pointer
   logic scan_hit;
   assign scan_hit = cur_used && cur_track == rq_track_ff && cur_scene == rq_scene_ff;

   // command update of the selected slot
   logic [1:0]  ap_mode, ap_phase;
   logic [2:0]  ap_quant;
   logic        ap_held;
   logic [31:0] ap_pend;
   logic [qlss_pkg::GRID_W-1:0] ap_retrig;

   always_comb begin
      ap_mode   = cur_mode;
      ap_quant  = cur_quant;
      ap_phase  = cur_phase;
      ap_held   = cur_held;
      ap_pend   = cur_pend;
      ap_retrig = cur_retrig;
      case (rq_type_ff)
         qlss_pkg::REQ_PRESS: begin
            ap_mode  = rq_mode_ff;
            ap_quant = rq_quant_ff;
            if (rq_mode_ff == qlss_pkg::MODE_TOGGLE && cur_phase == qlss_pkg::PH_LAUNCH) begin
               ap_phase = qlss_pkg::PH_IDLE;
            end else if (rq_mode_ff == qlss_pkg::MODE_TOGGLE &&
                         cur_phase == qlss_pkg::PH_PLAY) begin
               ap_held  = 1'b0;
               ap_phase = qlss_pkg::PH_STOP;
               ap_pend  = div_t;
            end else if (rq_mode_ff == qlss_pkg::MODE_TOGGLE &&
                         cur_phase == qlss_pkg::PH_STOP) begin
               ap_phase = qlss_pkg::PH_PLAY;
            end else begin
               if (rq_mode_ff == qlss_pkg::MODE_GATE || rq_mode_ff == qlss_pkg::MODE_REPEAT) begin
                  ap_held = 1'b1;
               end
               ap_retrig = grid_ff;
               ap_phase  = qlss_pkg::PH_LAUNCH;
               ap_pend   = div_t;
            end
         end
         qlss_pkg::REQ_RELEASE: begin
            if (cur_mode != qlss_pkg::MODE_TRIGGER && cur_mode != qlss_pkg::MODE_TOGGLE) begin
               ap_held = 1'b0;
               if (cur_phase == qlss_pkg::PH_LAUNCH) begin
                  ap_phase = qlss_pkg::PH_IDLE;
               end else if (cur_phase == qlss_pkg::PH_PLAY) begin
                  ap_phase = qlss_pkg::PH_STOP;
                  ap_pend  = div_t;
               end
            end
         end
         qlss_pkg::REQ_STOP: begin
            ap_held = 1'b0;
            if (cur_phase != qlss_pkg::PH_IDLE) begin
               ap_phase = qlss_pkg::PH_STOP;
               ap_pend  = div_t;
            end
         end
         default: ;
      endcase
   end

   // advance step of the slot at the pointer
   logic [31:0] pos32;
   logic [32:0] rep_next;
   logic        reach, rep_hit;
   logic [2:0]  adv_ev;
   logic [1:0]  adv_phase;

   always_comb begin
      pos32    = {1'b0, rq_pos_ff};
      reach    = pos32 >= cur_pend;
      rep_next = {1'b0, cur_start} + {15'd0, cur_retrig};
      rep_hit  = {1'b0, pos32} >= rep_next;
      adv_ev    = EV_NONE;
      adv_phase = cur_phase;
      if (cur_used) begin
         if (cur_phase == qlss_pkg::PH_LAUNCH && reach) begin
            adv_ev    = qlss_pkg::KIND_STARTED;
            adv_phase = qlss_pkg::PH_PLAY;
         end else if (cur_phase == qlss_pkg::PH_STOP && reach) begin
            adv_ev    = qlss_pkg::KIND_STOPPED;
            adv_phase = qlss_pkg::PH_IDLE;
         end else if (cur_mode == qlss_pkg::MODE_REPEAT && cur_phase == qlss_pkg::PH_PLAY &&
                      cur_held && cur_retrig != '0 && rep_hit) begin
            adv_ev = qlss_pkg::KIND_RETRIG;
         end
      end
   end

   // result fields by source
   logic            em_valid;
   logic [2:0]      em_kind;
   logic [IDXW-1:0] em_idx;
   logic [7:0]      em_track, em_scene;
   logic [1:0]      em_phase;
   logic [31:0]     em_sched;

   always_comb begin
      em_valid = 1'b0;
      em_kind  = cmd.emit_kind;
      em_idx   = '0;
      em_track = '0;
      em_scene = '0;
      em_phase = qlss_pkg::PH_IDLE;
      em_sched = '0;
      case (cmd.emit)
         qlss_pkg::EM_SLOT: begin
            em_valid = 1'b1;
            em_idx   = ptr_ff;
            em_track = cur_track;
            em_scene = cur_scene;
            em_phase = cur_phase;
            em_sched = cur_pend;
         end
         qlss_pkg::EM_REQ: begin
            em_valid = 1'b1;
            em_track = rq_track_ff;
            em_scene = rq_scene_ff;
         end
         qlss_pkg::EM_ZERO: begin
            em_valid = 1'b1;
         end
         qlss_pkg::EM_EVENT: begin
            em_valid = ev_cur != EV_NONE;
            em_kind  = ev_cur;
            em_idx   = ptr_ff;
            em_track = cur_track;
            em_scene = cur_scene;
            em_phase = (ev_cur == qlss_pkg::KIND_STOPPED) ? qlss_pkg::PH_IDLE : qlss_pkg::PH_PLAY;
            em_sched = cur_pend;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tpb_ff       <= qlss_pkg::TPB_RESET;
         ptr_ff       <= '0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
         launch_ff    <= '0;
         drop_ff      <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            used_ff[i] <= 1'b0;
            ev_ff[i]   <= EV_NONE;
         end
      end else begin
         if (csr_valid) begin
            tpb_ff <= csr_ticks_per_bar;
         end

         // pointer
         if (cmd.load_req || cmd.ptr_clr) begin
            ptr_ff <= '0;
         end else if (cmd.ptr_sel) begin
            ptr_ff <= match_ff ? match_idx_ff : free_idx_ff;
         end else if (cmd.ptr_inc) begin
            ptr_ff <= ptr_ff + IDXW'(1);
         end

         // search flags
         if (cmd.load_req) begin
            match_ff <= 1'b0;
            free_ff  <= 1'b0;
         end else if (cmd.scan) begin
            if (scan_hit && !match_ff) begin
               match_ff     <= 1'b1;
               match_idx_ff <= ptr_ff;
            end
            if (!cur_used && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= ptr_ff;
            end
         end

         if (cmd.drop_inc) begin
            drop_ff <= drop_ff + 32'd1;
         end

         // claim a free slot
         if (cmd.claim) begin
            used_ff[ptr_ff] <= 1'b1;
            active_ff       <= active_ff + ACTW'(1);
         end

         // advance: record event, count launches, free idle slots
         if (cmd.adv_eval) begin
            ev_ff[ptr_ff] <= adv_ev;
            if (adv_ev == qlss_pkg::KIND_STARTED || adv_ev == qlss_pkg::KIND_RETRIG) begin
               launch_ff <= launch_ff + 32'd1;
            end
            if (cur_used && adv_phase == qlss_pkg::PH_IDLE) begin
               used_ff[ptr_ff] <= 1'b0;
               active_ff       <= active_ff - ACTW'(1);
            end
         end

         if (cmd.clear_all) begin
            for (int i = 0; i < SLOTS; i++) begin
               used_ff[i] <= 1'b0;
            end
            active_ff <= '0;
            launch_ff <= '0;
         end

         rsp_valid_ff <= em_valid;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rq_type_ff  <= req_type;
         rq_track_ff <= req_track;
         rq_scene_ff <= req_scene;
         rq_mode_ff  <= req_launch_mode;
         rq_quant_ff <= req_quantisation;
         rq_pos_ff   <= req_position;
      end
      if (cmd.div_start) begin
         grid_ff <= grid_sel;
      end
      if (cmd.claim) begin
         track_ff[ptr_ff]  <= rq_track_ff;
         scene_ff[ptr_ff]  <= rq_scene_ff;
         phase_ff[ptr_ff]  <= qlss_pkg::PH_IDLE;
         held_ff[ptr_ff]   <= 1'b0;
         pend_ff[ptr_ff]   <= '0;
         start_ff[ptr_ff]  <= '0;
         retrig_ff[ptr_ff] <= '0;
      end
      if (cmd.apply) begin
         mode_ff[ptr_ff]   <= ap_mode;
         quant_ff[ptr_ff]  <= ap_quant;
         phase_ff[ptr_ff]  <= ap_phase;
         held_ff[ptr_ff]   <= ap_held;
         pend_ff[ptr_ff]   <= ap_pend;
         retrig_ff[ptr_ff] <= ap_retrig;
      end
      if (cmd.adv_eval && adv_ev != EV_NONE) begin
         phase_ff[ptr_ff] <= adv_phase;
         if (adv_ev == qlss_pkg::KIND_STARTED) begin
            start_ff[ptr_ff] <= cur_pend;
         end else if (adv_ev == qlss_pkg::KIND_RETRIG) begin
            start_ff[ptr_ff] <= rep_next[31:0];
         end else begin
            held_ff[ptr_ff] <= 1'b0;
         end
      end
      if (em_valid) begin
         rsp_kind_ff   <= em_kind;
         rsp_idx_ff    <= 4'(em_idx);
         rsp_track_ff  <= em_track;
         rsp_scene_ff  <= em_scene;
         rsp_phase_ff  <= em_phase;
         rsp_sched_ff  <= em_sched;
         rsp_launch_ff <= launch_ff;
         rsp_drop_ff   <= drop_ff;
         rsp_active_ff <= 5'(active_ff);
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign csr_ready = 1'b1;

   assign stat.req_type    = rq_type_ff;
   assign stat.ptr_last    = ptr_ff == LAST_IDX;
   assign stat.match_found = match_ff;
   assign stat.free_found  = free_ff;
   assign stat.div_done    = div_done;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_slot_index     = rsp_idx_ff;
   assign rsp_out_track      = rsp_track_ff;
   assign rsp_out_scene      = rsp_scene_ff;
   assign rsp_phase          = rsp_phase_ff;
   assign rsp_scheduled_tick = rsp_sched_ff;
   assign rsp_launch_total   = rsp_launch_ff;
   assign rsp_drop_total     = rsp_drop_ff;
   assign rsp_active_slots   = rsp_active_ff;
   assign rsp_last           = rsp_last_ff;

   `ASSERT_ALWAYS(a_active_bound, active_ff <= ACTW'(SLOTS), "occupied count above table size")
   `ASSERT_NEXT(a_gap_after_last, rsp_valid_ff && rsp_last_ff, !rsp_valid_ff,
                "result directly after final result")
endmodule

FILE: hdl/qlss_ctrl.sv
// Sequencer that steps the scheduler datapath through each request.
module qlss_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  qlss_pkg::dp_stat_type stat,
   output qlss_pkg::ctl_cmd_type cmd
);
   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_SEARCH,
      S_RESOLVE,
      S_CLAIM,
      S_DIV_START,
      S_DIV_WAIT,
      S_APPLY,
      S_RESULT,
      S_DROP,
      S_IGNORE,
      S_BADREQ,
      S_ADV_EVAL,
      S_ADV_EMIT,
      S_TICK,
      S_CLEAR,
      S_CLEARED
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.emit = qlss_pkg::EM_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.req_type) inside
               qlss_pkg::REQ_PRESS, qlss_pkg::REQ_RELEASE, qlss_pkg::REQ_STOP:
                  state_in = S_SEARCH;
               qlss_pkg::REQ_ADVANCE: state_in = S_ADV_EVAL;
               qlss_pkg::REQ_CLEAR:   state_in = S_CLEAR;
               default:               state_in = S_BADREQ;
            endcase
         end
         S_SEARCH: begin
            cmd.scan = 1'b1;
            if (stat.ptr_last) begin
               state_in = S_RESOLVE;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_RESOLVE: begin
            if (stat.match_found) begin
               cmd.ptr_sel = 1'b1;
               state_in = S_DIV_START;
            end else if (stat.req_type == qlss_pkg::REQ_PRESS && stat.free_found) begin
               cmd.ptr_sel = 1'b1;
               state_in = S_CLAIM;
            end else if (stat.req_type == qlss_pkg::REQ_PRESS) begin
               cmd.drop_inc = 1'b1;
               state_in = S_DROP;
            end else begin
               state_in = S_IGNORE;
            end
         end
         S_CLAIM: begin
            cmd.claim = 1'b1;
            state_in = S_DIV_START;
         end
         S_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (stat.div_done) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            cmd.emit = qlss_pkg::EM_SLOT;
            cmd.emit_kind = qlss_pkg::KIND_APPLIED;
            cmd.emit_last = 1'b1;
            state_in = S_IDLE;
         end
         S_DROP: begin
            cmd.emit = qlss_pkg::EM_REQ;
            cmd.emit_kind = qlss_pkg::KIND_DROPPED;
            cmd.emit_last = 1'b1;
            state_in = S_IDLE;
         end
         S_IGNORE: begin
            cmd.emit = qlss_pkg::EM_REQ;
            cmd.emit_kind = qlss_pkg::KIND_IGNORED;
            cmd.emit_last = 1'b1;
            state_in = S_IDLE;
         end
         S_BADREQ: begin
            cmd.emit = qlss_pkg::EM_ZERO;
            cmd.emit_kind = qlss_pkg::KIND_IGNORED;
            cmd.emit_last = 1'b1;
            state_in = S_IDLE;
         end
         S_ADV_EVAL: begin
            cmd.adv_eval = 1'b1;
            if (stat.ptr_last) begin
               cmd.ptr_clr = 1'b1;
               state_in = S_ADV_EMIT;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_ADV_EMIT: begin
            cmd.emit = qlss_pkg::EM_EVENT;
            if (stat.ptr_last) begin
               state_in = S_TICK;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_TICK: begin
            cmd.emit = qlss_pkg::EM_ZERO;
            cmd.emit_kind = qlss_pkg::KIND_TICK_DONE;
            cmd.emit_last = 1'b1;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_in = S_CLEARED;
         end
         S_CLEARED: begin
            cmd.emit = qlss_pkg::EM_ZERO;
            cmd.emit_kind = qlss_pkg::KIND_CLEARED;
            cmd.emit_last = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = state_ff != S_IDLE;
endmodule

FILE: hdl/quantised_launch_slot_scheduler_unit.sv
// Top level of the quantised launch slot scheduler.
//
// Request channel: drive req_* and raise start; the item is taken on the edge where
// start is high and busy is low. busy stays high until the item's work is done.
// Result channel: each result sits on rsp_* for one cycle with rsp_valid high;
// rsp_last marks the final result of an item. The receiver cannot stall.
// Config: csr_ticks_per_bar is written when csr_valid and csr_ready are high
// (csr_ready is always high); write only while no item is in flight.
// Sequence per item, while busy is high: press, release and stop walk the table
// once, then round the tick in a bit-serial remainder unit, which skips its
// steps when the grid is zero; a newly claimed slot adds a claim step. A dropped
// press or an unknown slot skips the rounding. Advance walks the table twice, one
// slot a cycle. Each result is registered and leaves in the cycle after its
// sequencer step; the final result is on the ports in the first cycle with busy
// low, when the next item can be taken.
// Reset: synchronous, active high; all slots free, totals zero, ticks per bar 192.
module quantised_launch_slot_scheduler_unit #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_track,
   input  logic [7:0]  req_scene,
   input  logic [1:0]  req_launch_mode,
   input  logic [2:0]  req_quantisation,
   input  logic [30:0] req_position,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_ticks_per_bar,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_slot_index,
   output logic [7:0]  rsp_out_track,
   output logic [7:0]  rsp_out_scene,
   output logic [1:0]  rsp_phase,
   output logic [31:0] rsp_scheduled_tick,
   output logic [31:0] rsp_launch_total,
   output logic [31:0] rsp_drop_total,
   output logic [4:0]  rsp_active_slots,
   output logic        rsp_last
);
   qlss_pkg::ctl_cmd_type cmd;
   qlss_pkg::dp_stat_type stat;

   qlss_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   qlss_dp #(.SLOTS(SLOTS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_type           (req_type),
      .req_track          (req_track),
      .req_scene          (req_scene),
      .req_launch_mode    (req_launch_mode),
      .req_quantisation   (req_quantisation),
      .req_position       (req_position),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_ticks_per_bar  (csr_ticks_per_bar),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_out_track      (rsp_out_track),
      .rsp_out_scene      (rsp_out_scene),
      .rsp_phase          (rsp_phase),
      .rsp_scheduled_tick (rsp_scheduled_tick),
      .rsp_launch_total   (rsp_launch_total),
      .rsp_drop_total     (rsp_drop_total),
      .rsp_active_slots   (rsp_active_slots),
      .rsp_last           (rsp_last)
   );
endmodule

FILE: sim/tb.sv
// Self-checking testbench for the quantised launch slot scheduler unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 16;
   localparam int IDLE_LIMIT = 5000;
   localparam logic [2:0] QUANT_BAR = 3'd1;
   localparam logic [2:0] QUANT_GLOBAL = 3'd4;
   localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  slot;
      logic [7:0]  trk;
      logic [7:0]  scn;
      logic [1:0]  ph;
      logic [31:0] sched;
      logic [31:0] ltot;
      logic [31:0] dtot;
      logic [4:0]  act;
      logic        last;
   } slot_event_type;

   typedef struct packed {
      logic [2:0]  rt;
      logic [7:0]  trk;
      logic [7:0]  scn;
      logic [1:0]  md;
      logic [2:0]  qz;
      logic [30:0] pos;
      logic        typed;
      logic [2:0]  ekind;
      logic [3:0]  eslot;
      logic [1:0]  eph;
      logic [31:0] esched;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_type = '0;
   logic [7:0]  req_track = '0;
   logic [7:0]  req_scene = '0;
   logic [1:0]  req_launch_mode = '0;
   logic [2:0]  req_quantisation = '0;
   logic [30:0] req_position = '0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_ticks_per_bar = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_kind;
   logic [3:0]  rsp_slot_index;
   logic [7:0]  rsp_out_track;
   logic [7:0]  rsp_out_scene;
   logic [1:0]  rsp_phase;
   logic [31:0] rsp_scheduled_tick;
   logic [31:0] rsp_launch_total;
   logic [31:0] rsp_drop_total;
   logic [4:0]  rsp_active_slots;
   logic        rsp_last;

   quantised_launch_slot_scheduler_unit #(.SLOTS(NSLOT)) dut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scheduler state mirror
   logic [15:0] bar_ticks = qlss_pkg::TPB_RESET;
   logic        s_used [NSLOT];
   logic [7:0]  s_trk [NSLOT];
   logic [7:0]  s_scn [NSLOT];
   logic [1:0]  s_mode [NSLOT];
   logic [2:0]  s_quant [NSLOT];
   logic [1:0]  s_phase [NSLOT];
   logic        s_held [NSLOT];
   logic [31:0] s_pending [NSLOT];
   logic [31:0] s_started [NSLOT];
   logic [31:0] s_rlen [NSLOT];
   logic [31:0] launches = '0;
   logic [31:0] drops = '0;

   slot_event_type expected_events[$];
   int             fails = 0;

   function automatic logic [31:0] grid_ticks(input logic [2:0] q);
      if (bar_ticks == 0 || q == qlss_pkg::QUANT_NONE) return 0;
      if (q == qlss_pkg::QUANT_FOUR) return 4 * bar_ticks;
      if (q == qlss_pkg::QUANT_TWO) return 2 * bar_ticks;
      return {16'd0, bar_ticks};
   endfunction

   function automatic logic [31:0] snap_tick(input logic [2:0] q, input logic [30:0] pos);
      longint unsigned g;
      longint unsigned r;
      g = grid_ticks(q);
      if (g == 0) return {1'b0, pos};
      r = ((longint'(pos) + g - 1) / g) * g;
      return r[31:0];
   endfunction

   function automatic void release_slot(input int i);
      s_used[i] = 1'b0;
      s_phase[i] = qlss_pkg::PH_IDLE;
      s_held[i] = 1'b0;
      s_pending[i] = 0;
      s_started[i] = 0;
      s_rlen[i] = 0;
   endfunction

   function automatic slot_event_type mk_event(input logic [2:0] k, input int i,
                                               input logic [7:0] t, input logic [7:0] s,
                                               input logic [1:0] p, input logic [31:0] sc);
      slot_event_type e;
      e = '0;
      e.kind = k;
      e.slot = i[3:0];
      e.trk = t;
      e.scn = s;
      e.ph = p;
      e.sched = sc;
      return e;
   endfunction

   // works out the results of one accepted item and queues them
   function automatic void schedule_request(input logic [2:0] rt, input logic [7:0] trk,
                                            input logic [7:0] scn, input logic [1:0] md,
                                            input logic [2:0] qz, input logic [30:0] pos);
      slot_event_type evs[$];
      slot_event_type e;
      int found;
      int act;
      logic [31:0] at;
      logic [2:0] ev;
      longint unsigned nxt;
      found = NSLOT;
      act = 0;
      if (rt == qlss_pkg::REQ_PRESS || rt == qlss_pkg::REQ_RELEASE ||
          rt == qlss_pkg::REQ_STOP) begin
         for (int i = 0; i < NSLOT; i++)
            if (found == NSLOT && s_used[i] && s_trk[i] == trk && s_scn[i] == scn) found = i;
         if (rt == qlss_pkg::REQ_PRESS && found == NSLOT) begin
            for (int i = 0; i < NSLOT; i++)
               if (found == NSLOT && !s_used[i]) begin
                  release_slot(i);
                  s_used[i] = 1'b1;
                  s_trk[i] = trk;
                  s_scn[i] = scn;
                  found = i;
               end
            if (found == NSLOT) begin
               drops++;
               evs.push_back(mk_event(qlss_pkg::KIND_DROPPED, 0, trk, scn,
                                      qlss_pkg::PH_IDLE, 0));
            end
         end
         if (found < NSLOT) begin
            if (rt == qlss_pkg::REQ_PRESS) begin
               at = snap_tick(qz, pos);
               s_mode[found] = md;
               s_quant[found] = qz;
               if (md == qlss_pkg::MODE_TOGGLE && s_phase[found] == qlss_pkg::PH_LAUNCH) begin
                  s_phase[found] = qlss_pkg::PH_IDLE;
               end else if (md == qlss_pkg::MODE_TOGGLE &&
                            s_phase[found] == qlss_pkg::PH_PLAY) begin
                  s_held[found] = 1'b0;
                  s_phase[found] = qlss_pkg::PH_STOP;
                  s_pending[found] = at;
               end else if (md == qlss_pkg::MODE_TOGGLE &&
                            s_phase[found] == qlss_pkg::PH_STOP) begin
                  s_phase[found] = qlss_pkg::PH_PLAY;
               end else begin
                  if (md == qlss_pkg::MODE_GATE || md == qlss_pkg::MODE_REPEAT)
                     s_held[found] = 1'b1;
                  s_rlen[found] = grid_ticks(qz);
                  s_phase[found] = qlss_pkg::PH_LAUNCH;
                  s_pending[found] = at;
               end
            end else if (rt == qlss_pkg::REQ_RELEASE) begin
               if (s_mode[found] == qlss_pkg::MODE_GATE ||
                   s_mode[found] == qlss_pkg::MODE_REPEAT) begin
                  s_held[found] = 1'b0;
                  if (s_phase[found] == qlss_pkg::PH_LAUNCH) begin
                     s_phase[found] = qlss_pkg::PH_IDLE;
                  end else if (s_phase[found] == qlss_pkg::PH_PLAY) begin
                     s_phase[found] = qlss_pkg::PH_STOP;
                     s_pending[found] = snap_tick(s_quant[found], pos);
                  end
               end
            end else begin
               s_held[found] = 1'b0;
               if (s_phase[found] != qlss_pkg::PH_IDLE) begin
                  s_phase[found] = qlss_pkg::PH_STOP;
                  s_pending[found] = snap_tick(s_quant[found], pos);
               end
            end
            evs.push_back(mk_event(qlss_pkg::KIND_APPLIED, found, trk, scn, s_phase[found],
                                   s_pending[found]));
         end else if (rt != qlss_pkg::REQ_PRESS) begin
            evs.push_back(mk_event(qlss_pkg::KIND_IGNORED, 0, trk, scn,
                                   qlss_pkg::PH_IDLE, 0));
         end
      end else if (rt == qlss_pkg::REQ_ADVANCE) begin
         for (int i = 0; i < NSLOT; i++) begin
            if (s_used[i]) begin
               ev = qlss_pkg::KIND_APPLIED;
               nxt = longint'(s_started[i]) + s_rlen[i];
               if (s_phase[i] == qlss_pkg::PH_LAUNCH && {1'b0, pos} >= s_pending[i]) begin
                  s_phase[i] = qlss_pkg::PH_PLAY;
                  s_started[i] = s_pending[i];
                  ev = qlss_pkg::KIND_STARTED;
               end else if (s_phase[i] == qlss_pkg::PH_STOP &&
                            {1'b0, pos} >= s_pending[i]) begin
                  s_phase[i] = qlss_pkg::PH_IDLE;
                  s_held[i] = 1'b0;
                  ev = qlss_pkg::KIND_STOPPED;
               end else if (s_mode[i] == qlss_pkg::MODE_REPEAT &&
                            s_phase[i] == qlss_pkg::PH_PLAY && s_held[i]
                            && s_rlen[i] > 0 && longint'(pos) >= nxt) begin
                  s_started[i] = nxt[31:0];
                  ev = qlss_pkg::KIND_RETRIG;
               end
               if (ev == qlss_pkg::KIND_STARTED || ev == qlss_pkg::KIND_RETRIG) launches++;
               if (ev != qlss_pkg::KIND_APPLIED)
                  evs.push_back(mk_event(ev, i, s_trk[i], s_scn[i], s_phase[i],
                                         s_pending[i]));
               if (s_phase[i] == qlss_pkg::PH_IDLE) release_slot(i);
            end
         end
         evs.push_back(mk_event(qlss_pkg::KIND_TICK_DONE, 0, 0, 0, qlss_pkg::PH_IDLE, 0));
      end else if (rt == qlss_pkg::REQ_CLEAR) begin
         for (int i = 0; i < NSLOT; i++) release_slot(i);
         launches = 0;
         evs.push_back(mk_event(qlss_pkg::KIND_CLEARED, 0, 0, 0, qlss_pkg::PH_IDLE, 0));
      end else begin
         evs.push_back(mk_event(qlss_pkg::KIND_IGNORED, 0, 0, 0, qlss_pkg::PH_IDLE, 0));
      end
      for (int i = 0; i < NSLOT; i++) if (s_used[i]) act++;
      foreach (evs[k]) begin
         e = evs[k];
         e.ltot = launches;
         e.dtot = drops;
         e.act = act[4:0];
         e.last = (k == evs.size() - 1);
         expected_events.push_back(e);
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      slot_event_type got;
      slot_event_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_kind, rsp_slot_index, rsp_out_track, rsp_out_scene, rsp_phase,
                rsp_scheduled_tick, rsp_launch_total, rsp_drop_total, rsp_active_slots,
                rsp_last};
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected item, actual %h", $time, got);
            fails++;
         end else begin
            want = expected_events.pop_front();
            if (got != want) begin
               $display("%0t: mismatch, expected %h actual %h", $time, want, got);
               fails++;
            end
         end
      end
   end

   // watchdog on cycles with no traffic
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   bit no_gaps = 1'b0;

   // drives one item and waits until it is taken
   task automatic send_item(input stim_row_type r);
      int first;
      req_type <= r.rt;
      req_track <= r.trk;
      req_scene <= r.scn;
      req_launch_mode <= r.md;
      req_quantisation <= r.qz;
      req_position <= r.pos;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      first = expected_events.size();
      schedule_request(r.rt, r.trk, r.scn, r.md, r.qz, r.pos);
      if (r.typed) begin
         expected_events[first].kind = r.ekind;
         expected_events[first].slot = r.eslot;
         expected_events[first].ph = r.eph;
         expected_events[first].sched = r.esched;
      end
      if (!no_gaps && $urandom_range(0, 99) < 22) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // waits for the block to drain, then writes ticks per bar
   task automatic write_bar_ticks(input logic [15:0] v);
      @(posedge clock);
      start <= 1'b0;
      while (expected_events.size() != 0 || busy) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_ticks_per_bar <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      bar_ticks = v;
      csr_valid <= 1'b0;
   endtask

   function automatic stim_row_type rand_item(inout logic [30:0] now);
      stim_row_type r;
      int pick;
      r = '0;
      pick = $urandom_range(0, 99);
      if (pick < 40) r.rt = qlss_pkg::REQ_PRESS;
      else if (pick < 55) r.rt = qlss_pkg::REQ_RELEASE;
      else if (pick < 65) r.rt = qlss_pkg::REQ_STOP;
      else if (pick < 92) r.rt = qlss_pkg::REQ_ADVANCE;
      else if (pick < 96) r.rt = qlss_pkg::REQ_CLEAR;
      else r.rt = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
      r.trk = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
      r.scn = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
      r.md = 2'($urandom);
      r.qz = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 19) == 0) now = 31'($urandom);
      else if (r.rt == qlss_pkg::REQ_ADVANCE)
         now = now + 31'($urandom_range(0, 3 * bar_ticks + 8));
      r.pos = (r.rt == qlss_pkg::REQ_ADVANCE) ? now : now + 31'($urandom_range(0, bar_ticks));
      return r;
   endfunction

   // directed items at the reset grid of 192 ticks
   stim_row_type directed[] = '{
      '{qlss_pkg::REQ_ADVANCE, 8'd0, 8'd0, qlss_pkg::MODE_TRIGGER, qlss_pkg::QUANT_NONE, 31'd0,
        1'b1, qlss_pkg::KIND_TICK_DONE, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{qlss_pkg::REQ_RELEASE, 8'd255, 8'd255, qlss_pkg::MODE_REPEAT, qlss_pkg::QUANT_NONE,
        31'd5, 1'b1, qlss_pkg::KIND_IGNORED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{qlss_pkg::REQ_STOP, 8'd255, 8'd0, qlss_pkg::MODE_TRIGGER, QUANT_BAR, 31'd5,
        1'b1, qlss_pkg::KIND_IGNORED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{REQ_UNUSED_LO, 8'd17, 8'd3, qlss_pkg::MODE_GATE, qlss_pkg::QUANT_TWO, 31'd9,
        1'b1, qlss_pkg::KIND_IGNORED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{REQ_UNUSED_MID, 8'd255, 8'd255, qlss_pkg::MODE_REPEAT, 3'd7, 31'h7FFFFFFF,
        1'b1, qlss_pkg::KIND_IGNORED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{REQ_UNUSED_HI, 8'd0, 8'd0, qlss_pkg::MODE_TRIGGER, qlss_pkg::QUANT_NONE, 31'd0,
        1'b1, qlss_pkg::KIND_IGNORED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{qlss_pkg::REQ_PRESS, 8'd0, 8'd0, qlss_pkg::MODE_TRIGGER, QUANT_BAR, 31'd1,
        1'b1, qlss_pkg::KIND_APPLIED, 4'd0, qlss_pkg::PH_LAUNCH, 32'd192},
      '{qlss_pkg::REQ_PRESS, 8'd255, 8'd255, qlss_pkg::MODE_GATE, qlss_pkg::QUANT_FOUR,
        31'h7FFFFFFF, 1'b0, qlss_pkg::KIND_APPLIED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{qlss_pkg::REQ_PRESS, 8'd1, 8'd0, qlss_pkg::MODE_TOGGLE, qlss_pkg::QUANT_TWO, 31'd100,
        1'b1, qlss_pkg::KIND_APPLIED, 4'd2, qlss_pkg::PH_LAUNCH, 32'd384},
      '{qlss_pkg::REQ_PRESS, 8'd2, 8'd0, qlss_pkg::MODE_REPEAT, QUANT_GLOBAL, 31'd0,
        1'b1, qlss_pkg::KIND_APPLIED, 4'd3, qlss_pkg::PH_LAUNCH, 32'd0},
      '{qlss_pkg::REQ_PRESS, 8'd3, 8'd170, qlss_pkg::MODE_TRIGGER, 3'd7, 31'd193,
        1'b1, qlss_pkg::KIND_APPLIED, 4'd4, qlss_pkg::PH_LAUNCH, 32'd384},
      '{qlss_pkg::REQ_PRESS, 8'd4, 8'd85, qlss_pkg::MODE_GATE, qlss_pkg::QUANT_NONE, 31'd12345,
        1'b1, qlss_pkg::KIND_APPLIED, 4'd5, qlss_pkg::PH_LAUNCH, 32'd12345},
      '{qlss_pkg::REQ_ADVANCE, 8'd0, 8'd0, qlss_pkg::MODE_TRIGGER, qlss_pkg::QUANT_NONE,
        31'd400, 1'b0, qlss_pkg::KIND_APPLIED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{qlss_pkg::REQ_ADVANCE, 8'd0, 8'd0, qlss_pkg::MODE_TRIGGER, qlss_pkg::QUANT_NONE,
        31'd2000, 1'b0, qlss_pkg::KIND_APPLIED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      // toggle on a playing slot, then on its pending stop
      '{qlss_pkg::REQ_PRESS, 8'd1, 8'd0, qlss_pkg::MODE_TOGGLE, qlss_pkg::QUANT_TWO, 31'd500,
        1'b0, qlss_pkg::KIND_APPLIED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{qlss_pkg::REQ_PRESS, 8'd1, 8'd0, qlss_pkg::MODE_TOGGLE, qlss_pkg::QUANT_TWO, 31'd600,
        1'b0, qlss_pkg::KIND_APPLIED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{qlss_pkg::REQ_RELEASE, 8'd255, 8'd255, qlss_pkg::MODE_TRIGGER, qlss_pkg::QUANT_NONE,
        31'd10, 1'b0, qlss_pkg::KIND_APPLIED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{qlss_pkg::REQ_RELEASE, 8'd0, 8'd0, qlss_pkg::MODE_TRIGGER, qlss_pkg::QUANT_NONE,
        31'd10, 1'b0, qlss_pkg::KIND_APPLIED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{qlss_pkg::REQ_STOP, 8'd4, 8'd85, qlss_pkg::MODE_TRIGGER, qlss_pkg::QUANT_NONE,
        31'd2100, 1'b0, qlss_pkg::KIND_APPLIED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{qlss_pkg::REQ_STOP, 8'd255, 8'd255, qlss_pkg::MODE_TRIGGER, qlss_pkg::QUANT_NONE,
        31'd2100, 1'b0, qlss_pkg::KIND_APPLIED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{qlss_pkg::REQ_ADVANCE, 8'd0, 8'd0, qlss_pkg::MODE_TRIGGER, qlss_pkg::QUANT_NONE,
        31'h7FFFFFFF, 1'b0, qlss_pkg::KIND_APPLIED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{qlss_pkg::REQ_CLEAR, 8'd9, 8'd9, qlss_pkg::MODE_TRIGGER, qlss_pkg::QUANT_NONE, 31'd0,
        1'b1, qlss_pkg::KIND_CLEARED, 4'd0, qlss_pkg::PH_IDLE, 32'd0},
      '{qlss_pkg::REQ_ADVANCE, 8'd0, 8'd0, qlss_pkg::MODE_TRIGGER, qlss_pkg::QUANT_NONE, 31'd0,
        1'b1, qlss_pkg::KIND_TICK_DONE, 4'd0, qlss_pkg::PH_IDLE, 32'd0}
   };

   logic [15:0] grid_plan[] = '{16'd65535, 16'd0, 16'd1, 16'd7, 16'd192};

   // main sequence
   initial begin
      logic [30:0] now;
      now = '0;
      for (int i = 0; i < NSLOT; i++) release_slot(i);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_item(directed[i]);
      foreach (grid_plan[p]) begin
         write_bar_ticks((p == grid_plan.size() - 1) ? 16'($urandom) : grid_plan[p]);
         now = '0;
         no_gaps = (p == 2);
         repeat (80) send_item(rand_item(now));
      end
      @(posedge clock);
      start <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fails == 0 && expected_events.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
